/* src/lmps_pkg.sv */
`default_nettype none

package lmps_pkg;

  // matrix geometry
  localparam int ROW_COUNT   = 8;
  localparam int LEVEL_COUNT = 15;
  localparam int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  // two slots per row: one displayed, one holding the newest shadow word
  localparam int SLOT_AW     = ROW_W + 1;
  localparam int SLOT_DEPTH  = 2 ** SLOT_AW;

  // pixel word layout
  localparam int WORD_W      = 32;
  localparam int NIB_W       = 4;
  localparam int COL_COUNT   = 8;
  localparam int SUB_W       = 4;
  localparam int SEL_W       = 3;

  // result queue
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_PRESENT = 2'd2;

  // one result word
  typedef struct packed {
    logic [SEL_W-1:0]     row_select;
    logic [COL_COUNT-1:0] column_drive;
  } out_word_t;

  // column bit b lit when nibble b exceeds the subframe level
  function automatic logic [COL_COUNT-1:0] column_byte(input logic [WORD_W-1:0] word,
                                                       input logic [SUB_W-1:0]  level);
    logic [COL_COUNT-1:0] bits;
    bits = '0;
    for (int b = 0; b < COL_COUNT; b++) begin
      bits[b] = (word[NIB_W*b +: NIB_W] > level);
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

/* src/lmps_ram.sv */
`default_nettype none

module lmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/lmps_outq.sv */
`default_nettype none

module lmps_outq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push_valid,
  input  wire lmps_pkg::out_word_t       push_word,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output lmps_pkg::out_word_t            out_word,
  output logic                           pop,
  output logic [lmps_pkg::QCNT_W-1:0]    count
);

  import lmps_pkg::*;

  out_word_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // head of queue drives the result port
  assign out_valid = (count_r != '0);
  assign out_word  = entry_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count     = count_r;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

/* src/led_matrix_pwm_scanner.sv */
`default_nettype none

// channel  | handshake          | fields
// in       | in_valid/in_stall  | in_command, in_row_index, in_row_pixels
// out      | out_valid/out_stall| out_row_select, out_column_drive
//
// one word accepted per cycle while in_stall is low; a scan tick's result passes a registered
// pixel memory read, then a column compare into a three-word result queue
// in_stall rises only while three tick results are in flight or queued
// out_stall holds the queue head; write and present words keep flowing until full
// synchronous active-low reset blanks the display: row slots read as zero until written
// no clearing pass after reset

module led_matrix_pwm_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [2:0]  in_row_index,
  input  wire logic [31:0] in_row_pixels,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_row_select,
  output logic [7:0]       out_column_drive
);

  import lmps_pkg::*;

  logic                  in_acc, tick_acc, wr_acc, pres_acc;
  logic [ROW_W-1:0]      wr_row;
  logic                  at_start, do_copy;
  logic [ROW_COUNT-1:0]  disp_sel_r, disp_sel_nxt;
  logic [ROW_COUNT-1:0]  shad_sel_r, shad_sel_nxt;
  logic [SLOT_DEPTH-1:0] slot_valid_r, slot_valid_nxt;
  logic                  pending_r, pending_nxt;
  logic [ROW_W-1:0]      scan_row_r, scan_row_nxt;
  logic [SUB_W-1:0]      sub_r, sub_nxt;
  logic                  rd_slot, wr_slot;
  logic [SLOT_AW-1:0]    rd_addr, wr_addr;
  logic [WORD_W-1:0]     rd_data;
  logic                  s1_v_r;
  logic [SEL_W-1:0]      s1_row_r;
  logic [SUB_W-1:0]      s1_sub_r;
  logic                  s1_ok_r;
  out_word_t             push_word, head_word;
  logic                  out_pop;
  logic [QCNT_W-1:0]     q_count;
  logic [QCNT_W:0]       in_flight;

  // input decode
  assign in_acc   = in_valid && !in_stall;
  assign tick_acc = in_acc && (in_command == CMD_TICK);
  assign pres_acc = in_acc && (in_command == CMD_PRESENT);
  assign wr_acc   = in_acc && (in_command == CMD_WRITE) && (int'(in_row_index) < ROW_COUNT);
  assign wr_row   = ROW_W'(in_row_index);

  // present takes effect at a scan-start tick by copying each row's shadow slot choice to its displayed slot
  assign at_start = (scan_row_r == '0) && (sub_r == '0);
  assign do_copy  = tick_acc && at_start && pending_r;
  assign disp_sel_nxt = do_copy ? shad_sel_r : disp_sel_r;

  // display read address
  assign rd_slot = disp_sel_nxt[scan_row_r];
  assign rd_addr = {rd_slot, scan_row_r};

  // shadow write goes to the slot not on display
  assign wr_slot = (shad_sel_r[wr_row] == disp_sel_r[wr_row]) ? !disp_sel_r[wr_row]
                                                              : shad_sel_r[wr_row];
  assign wr_addr = {wr_slot, wr_row};

  always_comb begin
    shad_sel_nxt   = shad_sel_r;
    slot_valid_nxt = slot_valid_r;
    if (wr_acc) begin
      shad_sel_nxt[wr_row]    = wr_slot;
      slot_valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    if (pres_acc) begin
      pending_nxt = 1'b1;
    end else if (do_copy) begin
      pending_nxt = 1'b0;
    end
  end

  // row then subframe scan counters
  always_comb begin
    scan_row_nxt = scan_row_r;
    sub_nxt      = sub_r;
    if (tick_acc) begin
      if (scan_row_r == ROW_W'(ROW_COUNT - 1)) begin
        scan_row_nxt = '0;
        sub_nxt      = (sub_r == SUB_W'(LEVEL_COUNT - 1)) ? '0 : sub_r + 1'b1;
      end else begin
        scan_row_nxt = scan_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_sel_r   <= '0;
      shad_sel_r   <= '0;
      slot_valid_r <= '0;
      pending_r    <= 1'b0;
      scan_row_r   <= '0;
      sub_r        <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      disp_sel_r   <= disp_sel_nxt;
      shad_sel_r   <= shad_sel_nxt;
      slot_valid_r <= slot_valid_nxt;
      pending_r    <= pending_nxt;
      scan_row_r   <= scan_row_nxt;
      sub_r        <= sub_nxt;
      s1_v_r       <= tick_acc;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_row_r <= SEL_W'(scan_row_r);
      s1_sub_r <= sub_r;
      s1_ok_r  <= slot_valid_r[rd_addr];
    end
  end

  // pixel memory, both slots of every row
  lmps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_DEPTH)
  ) u_pixel_ram (
    .clk     (clk),
    .wr_en   (wr_acc),
    .wr_addr (wr_addr),
    .wr_data (in_row_pixels),
    .rd_en   (tick_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // column compare, unwritten slots read blank
  assign push_word.row_select   = s1_row_r;
  assign push_word.column_drive = s1_ok_r ? column_byte(rd_data, s1_sub_r) : '0;

  lmps_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (s1_v_r),
    .push_word  (push_word),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_word   (head_word),
    .pop        (out_pop),
    .count      (q_count)
  );

  assign out_row_select   = head_word.row_select;
  assign out_column_drive = head_word.column_drive;

  // credit check from registered state only
  assign in_flight = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_v_r};
  assign in_stall  = (in_flight >= (QCNT_W + 1)'(QUEUE_DEPTH));

  // every accepted tick reaches the read stage
  a_tick_reads: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> s1_v_r)
    else $error("tick did not enter read stage");

  // the queue is never pushed while full and not draining
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_pop) |-> (q_count != QCNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  // a shadow write never lands on the displayed slot
  a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc |-> (wr_slot != disp_sel_r[wr_row]))
    else $error("shadow write hit displayed slot");

  // present request is consumed by the copy at scan start
  a_present_done: assert property (@(posedge clk) disable iff (!rst_n)
    do_copy |=> !pending_r)
    else $error("present still pending after copy");

endmodule

`default_nettype wire
